/* hdl/mexp_pkg.sv */
// mexp_pkg: field widths and controller state type for the modular exponentiation block.
// No dependencies; imported by modular_exponentiation.
`timescale 1ns / 1ps

package mexp_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned BASE_W = 63;
  localparam int unsigned EXP_W  = 63;
  localparam int unsigned MOD_W  = 61;
  localparam int unsigned OUT_W  = 61;

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for a request
    S_RED,   // serial reduction of the base by the modulus
    S_DBL,   // double-and-reduce step of a modular product
    S_ADD,   // add-and-reduce step, taken when the multiplier bit is set
    S_OUT    // hand the result to the output register
  } mexp_state_e;

endpackage

/* hdl/modular_exponentiation.sv */
// modular_exponentiation: square-and-multiply modular power with a bit-serial product.
// Depends on mexp_pkg (field widths, state type).
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_ready_o) carries one request: base_value_i,
//   exponent_i, modulus_i. Only the low EXP_BITS exponent bits and the low MOD_BITS
//   modulus bits are used. A modulus below 2 returns 0.
// - Output channel (out_valid_o / out_ready_i) returns power_result_o, one per request.
// - One request at a time: in_ready_o is high only while the controller is idle.
// - Work per request:
//     S_RED first reduces the base (one base bit per cycle, restoring remainder),
//     then for each of EXP_BITS exponent bits a squaring and, if the bit is set,
//     a multiply. Each product scans MOD_BITS multiplier bits, a double step (S_DBL)
//     per bit plus an add step (S_ADD) for every set multiplier bit.
//     S_OUT then moves the result into the output register.
//   A single shared add/compare/subtract unit serves all of these steps.
// - A finished result waits in the output register; the controller holds the
//   next result until that register is free, and then returns to idle.
// - Reset clears the controller and the output valid; other registers are not reset.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 63,
  parameter int unsigned MOD_BITS = 61
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mexp_pkg::BASE_W-1:0]    base_value_i,
  input  logic [mexp_pkg::EXP_W-1:0]     exponent_i,
  input  logic [mexp_pkg::MOD_W-1:0]     modulus_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mexp_pkg::OUT_W-1:0]     power_result_o
);

  import mexp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(BASE_W);
  localparam int unsigned ECNT_W = $clog2(EXP_BITS);

  mexp_state_e state_q, state_d;

  logic [MOD_BITS-1:0] m_q, m_d;       // modulus
  logic [MOD_BITS-1:0] a_q, a_d;       // running power value
  logic [MOD_BITS-1:0] b_q, b_d;       // reduced base
  logic [MOD_BITS-1:0] p_q, p_d;       // product / remainder accumulator
  logic [MOD_BITS-1:0] y_q, y_d;       // multiplier shift register, MSB first
  logic [BASE_W-1:0]   bsh_q, bsh_d;   // base shift register for the reduction
  logic [EXP_BITS-1:0] e_q, e_d;       // exponent shift register, MSB first
  logic [CNT_W-1:0]    cnt_q, cnt_d;   // bits left in the reduction or product
  logic [ECNT_W-1:0]   ecnt_q, ecnt_d; // exponent bits left
  logic                sq_q, sq_d;     // current product is a squaring
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_q, out_d;

  // Shared unit: the accumulator shifted up a bit, or the sum p + a, then a conditional subtract of m
  logic [MOD_BITS:0]   add_t;
  logic [MOD_BITS+1:0] add_diff;
  logic [MOD_BITS-1:0] red;
  logic                step;

  logic [MOD_BITS-1:0] m_in;
  logic                m_small;

  assign m_in    = modulus_i[MOD_BITS-1:0];
  assign m_small = (m_in < MOD_BITS'(2));

  always_comb begin
    case (state_q)
      S_RED:   add_t = {p_q, bsh_q[BASE_W-1]};
      S_DBL:   add_t = {p_q, 1'b0};
      S_ADD:   add_t = {1'b0, p_q} + {1'b0, a_q};
      default: add_t = '0;
    endcase
    add_diff = {1'b0, add_t} - {2'b00, m_q};
    red      = add_diff[MOD_BITS+1] ? add_t[MOD_BITS-1:0] : add_diff[MOD_BITS-1:0];
  end

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    a_d         = a_q;
    b_d         = b_q;
    p_d         = p_q;
    y_d         = y_q;
    bsh_d       = bsh_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    step        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          m_d    = m_in;
          e_d    = exponent_i[EXP_BITS-1:0];
          ecnt_d = ECNT_W'(EXP_BITS - 1);
          bsh_d  = base_value_i;
          p_d    = '0;
          cnt_d  = CNT_W'(BASE_W - 1);
          a_d    = m_small ? '0 : MOD_BITS'(1);
          state_d = m_small ? S_OUT : S_RED;
        end
      end
      S_RED: begin
        p_d   = red;
        bsh_d = {bsh_q[BASE_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          // base reduced; first squaring of the leading exponent bit
          b_d     = red;
          y_d     = a_q;
          sq_d    = 1'b1;
          p_d     = '0;
          cnt_d   = CNT_W'(MOD_BITS - 1);
          state_d = S_DBL;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_DBL: begin
        p_d = red;
        if (y_q[MOD_BITS-1]) begin
          state_d = S_ADD;
        end else begin
          step = 1'b1;
        end
      end
      S_ADD: begin
        p_d  = red;
        step = 1'b1;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = OUT_W'(a_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to the next multiplier bit, closing the product on its last bit
    if (step) begin
      y_d     = {y_q[MOD_BITS-2:0], 1'b0};
      state_d = S_DBL;
      if (cnt_q == '0) begin
        a_d   = red;
        p_d   = '0;
        cnt_d = CNT_W'(MOD_BITS - 1);
        if (sq_q && e_q[EXP_BITS-1]) begin
          y_d  = b_q;
          sq_d = 1'b0;
        end else begin
          e_d  = {e_q[EXP_BITS-2:0], 1'b0};
          y_d  = red;
          sq_d = 1'b1;
          if (ecnt_q == '0) begin
            state_d = S_OUT;
          end else begin
            ecnt_d = ecnt_q - ECNT_W'(1);
          end
        end
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    a_q    <= a_d;
    b_q    <= b_d;
    p_q    <= p_d;
    y_q    <= y_d;
    bsh_q  <= bsh_d;
    e_q    <= e_d;
    cnt_q  <= cnt_d;
    ecnt_q <= ecnt_d;
    sq_q   <= sq_d;
    out_q  <= out_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

  // A taken request starts either the base reduction or the small-modulus shortcut
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_RED || state_q == S_OUT)
    else $error("request did not start work");

  // The accumulator stays fully reduced while working
  a_p_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED || state_q == S_DBL || state_q == S_ADD) |-> p_q < m_q)
    else $error("accumulator not reduced");

  // Product operands stay below the modulus
  a_ops_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DBL || state_q == S_ADD) |-> a_q < m_q && b_q < m_q)
    else $error("product operand not reduced");

  // A result appears only out of the hand-off state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside hand-off");

endmodule

/* dv/tb_modular_exponentiation.sv */
// tb_modular_exponentiation: self-checking bench for the modular power block.
// Depends on mexp_pkg and modular_exponentiation; a scoreboard class predicts results
// with wide-integer arithmetic; tasks drive requests and an initial block drives result ready.
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int unsigned EXP_BITS = 63;
  localparam int unsigned MOD_BITS = 61;

  // The quiet limit is several times longer than one request or the long hold-off.
  localparam int unsigned QUIET_LIMIT  = 200_000;
  // Long enough for two requests to finish so the block fills and stalls its input.
  localparam int unsigned HOLD_CYCLES  = 40_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RAND_REQS    = 80;

  // Scoreboard: predicts base^exponent mod modulus for each accepted request and
  // checks results in order against the oldest prediction.
  class power_scoreboard;
    bit [OUT_W-1:0] expected_powers[$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Square-and-multiply over the used exponent bits, products taken full width.
    function bit [OUT_W-1:0] mod_power(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e,
                                       bit [MOD_W-1:0] m);
      bit [63:0]  e_used;
      bit [63:0]  m_used;
      bit [127:0] wide_mod;
      bit [127:0] wide_base;
      bit [127:0] acc;
      int         k;
      e_used = 64'(e) & ((64'd1 << EXP_BITS) - 64'd1);
      m_used = 64'(m) & ((64'd1 << MOD_BITS) - 64'd1);
      // Out-of-range modulus (zero or one) gives a fixed zero
      if (m_used < 64'd2) return '0;
      wide_mod  = 128'(m_used);
      wide_base = 128'(b) % wide_mod;
      acc       = 128'd1;
      for (k = int'(EXP_BITS) - 1; k >= 0; k--) begin
        acc = (acc * acc) % wide_mod;
        if (e_used[k]) acc = (acc * wide_base) % wide_mod;
      end
      return acc[OUT_W-1:0];
    endfunction

    function void note_request(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e, bit [MOD_W-1:0] m);
      expected_powers.insert(expected_powers.size(), mod_power(b, e, m));
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      bit [OUT_W-1:0] want;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected power_result %h, nothing outstanding", $time, got);
        mismatches++;
        return;
      end
      want = expected_powers.pop_front();
      if (got !== want) begin
        $display("%0t: power_result mismatch, expected %h, actual %h", $time, want, got);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_powers.size();
    endfunction
  endclass

  power_scoreboard sb = new();

  // Clock, reset and the two channels; every input starts at a known value.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              req_valid    = 1'b0;
  logic              req_ready;
  logic [BASE_W-1:0] base_value   = '0;
  logic [EXP_W-1:0]  exponent     = '0;
  logic [MOD_W-1:0]  modulus      = '0;
  logic              res_valid;
  logic              res_ready    = 1'b1;
  logic [OUT_W-1:0]  power_result;

  // Idling controls shared between the stimulus and the result sink
  bit src_idle_en   = 1'b1;
  bit sink_stall_en = 1'b1;
  bit hold_outputs  = 1'b0;

  modular_exponentiation #(
    .EXP_BITS(EXP_BITS),
    .MOD_BITS(MOD_BITS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .base_value_i  (base_value),
    .exponent_i    (exponent),
    .modulus_i     (modulus),
    .out_valid_o   (res_valid),
    .out_ready_i   (res_ready),
    .power_result_o(power_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Handshakes are sampled right at the edge, before any of this edge's updates land,
  // so the bench sees exactly what the block saw.
  always @(posedge clk) begin
    if (req_valid && req_ready) sb.note_request(base_value, exponent, modulus);
    if (res_valid && res_ready) sb.check_result(power_result);
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result sink: short random stall bursts, plus one long hold-off on request.
  // The hold-off is counted here so the stimulus keeps offering requests meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_ready <= 1'b1;
        hold_outputs = 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        res_ready <= 1'b1;
      end
    end
  end

  // Random value of the given width, low bits only
  function automatic bit [63:0] rand_bits(int unsigned width);
    bit [63:0] v;
    v = {$urandom, $urandom};
    if (width < 64) v &= (64'd1 << width) - 64'd1;
    return v;
  endfunction

  // Offer one request and hold it until accepted. Called at a rising edge; returns
  // at the accepting edge, optionally after a short source gap. Valid is left high
  // when there is no gap so back-to-back requests need no extra step.
  task automatic send_power_request(input bit [BASE_W-1:0] b, input bit [EXP_W-1:0] e,
                                    input bit [MOD_W-1:0] m);
    req_valid  <= 1'b1;
    base_value <= b;
    exponent   <= e;
    modulus    <= m;
    do @(posedge clk); while (!(req_valid && req_ready));
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Random request: mostly full-width fields, with small and out-of-range moduli,
  // short exponents and small bases mixed in.
  task automatic send_random_request();
    bit [BASE_W-1:0] b;
    bit [EXP_W-1:0]  e;
    bit [MOD_W-1:0]  m;
    case ($urandom_range(0, 19))
      0:       m = MOD_W'($urandom_range(0, 1));
      1, 2, 3: m = MOD_W'(rand_bits($urandom_range(2, 16)));
      4:       m = '1;
      default: m = MOD_W'(rand_bits(MOD_W));
    endcase
    case ($urandom_range(0, 9))
      0:       b = '0;
      1, 2:    b = BASE_W'(rand_bits($urandom_range(1, 62)));
      default: b = BASE_W'(rand_bits(BASE_W));
    endcase
    case ($urandom_range(0, 9))
      0:       e = '0;
      1, 2, 3: e = EXP_W'(rand_bits($urandom_range(1, 62)));
      default: e = EXP_W'(rand_bits(EXP_W));
    endcase
    send_power_request(b, e, m);
  endtask

  // Sender pause: wait at clock edges until every outstanding result is back.
  // The first edge lets the scoreboard log a request accepted at the calling edge.
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned i;

    // Asynchronous reset, held low from time zero and released on an edge
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: field extremes and every special case
    send_power_request('0, '0, MOD_W'(2));                      // zero exponent -> 1
    send_power_request('0, EXP_W'(5), '1);                      // zero base
    send_power_request('1, '1, '1);                             // all fields at maximum
    send_power_request('1, EXP_W'(1), MOD_W'(2));               // smallest legal modulus
    send_power_request('1, '1, '0);                             // modulus zero -> 0
    send_power_request('1, '1, MOD_W'(1));                      // modulus one -> 0
    send_power_request('0, '0, '0);                             // zero exponent, modulus zero
    send_power_request('0, '0, MOD_W'(1));                      // zero exponent, modulus one
    send_power_request(BASE_W'(12345), '0, '1);                 // zero exponent, big modulus
    send_power_request(BASE_W'(61'h1FFF_FFFF_FFFF_FFFF), EXP_W'(3), '1); // base equal to modulus
    send_power_request(BASE_W'(62'h2000_0000_0000_0000), EXP_W'(7), '1); // base above modulus
    send_power_request(BASE_W'(3), EXP_W'(63'h4000_0000_0000_0000), '1); // top exponent bit only
    send_power_request(BASE_W'(987654321), EXP_W'(1), MOD_W'(1_000_000_007)); // single multiply
    send_power_request(BASE_W'(2), '1, MOD_W'(3));
    // Fermat on the prime 2^61-1: 3^(p-1) = 1
    send_power_request(BASE_W'(3), EXP_W'(61'h1FFF_FFFF_FFFF_FFFE), '1);
    send_power_request(BASE_W'(1), '1, MOD_W'(61'h1000_0000_0000_0000));
    send_power_request('1, EXP_W'(2), MOD_W'(61'h1000_0000_0000_0000)); // power-of-two modulus
    send_power_request(BASE_W'(63'h5555_5555_5555_5555), EXP_W'(63'h2AAA_AAAA_AAAA_AAAA),
                       MOD_W'(61'h0AAA_AAAA_AAAA_AAAB));
    send_power_request(BASE_W'(63'h2AAA_AAAA_AAAA_AAAA), EXP_W'(63'h5555_5555_5555_5555),
                       MOD_W'(61'h1555_5555_5555_5555));
    send_power_request('1, '1, MOD_W'(255));
    wait_results_drained();

    // Long result hold-off: keep offering requests until the block stalls its input
    src_idle_en  = 1'b0;
    hold_outputs = 1'b1;
    repeat (3) send_random_request();
    wait_results_drained();

    // Random requests; the tail runs with no idling on either side
    src_idle_en = 1'b1;
    for (i = 0; i < RAND_REQS; i++) begin
      src_idle_en   = (i < RAND_REQS - 20);
      sink_stall_en = (i < RAND_REQS - 20);
      send_random_request();
    end
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mexp_pkg.sv
hdl/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
